@@ sv/i2r_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package i2r_pkg;

  // Field widths
  localparam int IN_W       = 32;
  localparam int SYM_W      = 8;
  localparam int CFG_W      = 64;
  localparam int CFG_IDX_W  = 2;
  localparam int RADIX_W    = 5;

  // Conversion sizing
  localparam int VALUE_BITS = 32;
  localparam int MAX_RADIX  = 16;
  localparam int REM_W      = $clog2(MAX_RADIX);
  localparam int STEP_BITS  = 4;
  localparam int DIV_STEPS  = (VALUE_BITS + STEP_BITS - 1) / STEP_BITS;
  localparam int DIV_W      = DIV_STEPS * STEP_BITS;
  localparam int STEP_CNT_W = $clog2(DIV_STEPS);
  localparam int IDX_W      = $clog2(VALUE_BITS);
  localparam int CNT_W      = $clog2(VALUE_BITS + 1);

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_RADIX        = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SYMBOLS_LOW  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SYMBOLS_HIGH = 2'd2;

  // Register reset values: "01234567" and "89ABCDEF", digit 0 in the low byte
  localparam logic [RADIX_W-1:0] RADIX_RESET        = 5'd10;
  localparam logic [CFG_W-1:0]   SYMBOLS_LOW_RESET  = 64'h3736_3534_3332_3130;
  localparam logic [CFG_W-1:0]   SYMBOLS_HIGH_RESET = 64'h4645_4443_4241_3938;

  localparam logic [SYM_W-1:0] MINUS_SYMBOL = 8'h2D;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic div_step;
    logic push_digit;
    logic emit_sign;
    logic emit_digit;
  } i2r_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic negative;
    logic quot_zero;
    logic first_digit;
  } i2r_status_t;

endpackage

`default_nettype wire

@@ sv/i2r_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module i2r_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  i2r_pkg::i2r_status_t status,
  output i2r_pkg::i2r_cmd_t    cmd,
  output logic                 busy
);
  import i2r_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DIV  = 3'd1;
  localparam logic [2:0] ST_PUSH = 3'd2;
  localparam logic [2:0] ST_SIGN = 3'd3;
  localparam logic [2:0] ST_EMIT = 3'd4;

  localparam logic [STEP_CNT_W-1:0] LAST_STEP = STEP_CNT_W'(DIV_STEPS - 1);

  logic [2:0]            state;
  logic [2:0]            state_next;
  logic [STEP_CNT_W-1:0] step_cnt;
  logic [STEP_CNT_W-1:0] step_cnt_next;

  // Sequence: divide, push digit, repeat until quotient is zero, then emit sign (if negative) and digits
  always_comb begin
    state_next    = state;
    step_cnt_next = step_cnt;
    cmd           = '0;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.load      = 1'b1;
          step_cnt_next = '0;
          state_next    = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_step  = 1'b1;
        step_cnt_next = step_cnt + 1'b1;
        if (step_cnt == LAST_STEP) begin
          state_next = ST_PUSH;
        end
      end
      ST_PUSH: begin
        cmd.push_digit = 1'b1;
        step_cnt_next  = '0;
        if (!status.quot_zero) begin
          state_next = ST_DIV;
        end else if (status.negative) begin
          state_next = ST_SIGN;
        end else begin
          state_next = ST_EMIT;
        end
      end
      ST_SIGN: begin
        cmd.emit_sign = 1'b1;
        state_next    = ST_EMIT;
      end
      ST_EMIT: begin
        cmd.emit_digit = 1'b1;
        if (status.first_digit) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Hold state and step count
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      step_cnt <= '0;
    end else begin
      state    <= state_next;
      step_cnt <= step_cnt_next;
    end
  end

  assign busy = (state != ST_IDLE);

`ifndef SYNTH
  a_div_exit: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV && step_cnt != LAST_STEP) |=> (state == ST_DIV))
    else $error("divider left early");
  a_sign_then_emit: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SIGN) |=> (state == ST_EMIT))
    else $error("sign not followed by digits");
  a_push_count: assert property (@(posedge clk) disable iff (rst)
    (state == ST_PUSH) |-> ($past(state) == ST_DIV && $past(step_cnt) == LAST_STEP))
    else $error("digit pushed before division finished");
`endif

endmodule

`default_nettype wire

@@ sv/i2r_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none

module i2r_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  i2r_pkg::i2r_cmd_t             cmd,
  input  logic signed [i2r_pkg::IN_W-1:0] value,
  input  logic [i2r_pkg::RADIX_W-1:0]   radix,
  input  logic [2*i2r_pkg::CFG_W-1:0]   alphabet,
  output i2r_pkg::i2r_status_t          status,
  output logic [i2r_pkg::SYM_W-1:0]     symbol,
  output logic                          last,
  output logic                          strobe
);
  import i2r_pkg::*;

  localparam logic [RADIX_W-1:0] RADIX_MIN = RADIX_W'(2);
  localparam logic [RADIX_W-1:0] RADIX_MAX = RADIX_W'(MAX_RADIX);

  logic [DIV_W-1:0]      dividend;
  logic [REM_W-1:0]      rem;
  logic                  negative;
  logic [CNT_W-1:0]      digit_cnt;
  logic [IDX_W-1:0]      rd_ptr;
  logic [REM_W-1:0]      digits [VALUE_BITS];

  logic [VALUE_BITS-1:0] raw;
  logic [VALUE_BITS-1:0] magnitude;
  logic [RADIX_W-1:0]    eff_radix;
  logic [DIV_W-1:0]      dividend_next;
  logic [REM_W-1:0]      rem_next;

  // Take the magnitude; the most negative value maps to 2^(VALUE_BITS-1)
  assign raw       = value[VALUE_BITS-1:0];
  assign magnitude = raw[VALUE_BITS-1] ? (~raw + 1'b1) : raw;

  // Clamp radix into the legal range
  always_comb begin
    if (radix < RADIX_MIN) begin
      eff_radix = RADIX_MIN;
    end else if (radix > RADIX_MAX) begin
      eff_radix = RADIX_MAX;
    end else begin
      eff_radix = radix;
    end
  end

  // Four restoring division steps per cycle, quotient bits shift in below
  always_comb begin
    logic [REM_W:0]       trial;
    logic [STEP_BITS-1:0] qbits;
    trial = '0;
    qbits = '0;
    rem_next = rem;
    for (int i = 0; i < STEP_BITS; i++) begin
      trial = {rem_next, dividend[DIV_W-1-i]};
      if (trial >= (REM_W+1)'(eff_radix)) begin
        trial = trial - (REM_W+1)'(eff_radix);
        qbits[STEP_BITS-1-i] = 1'b1;
      end
      rem_next = trial[REM_W-1:0];
    end
    dividend_next = {dividend[DIV_W-STEP_BITS-1:0], qbits};
  end

  // Advance the division and collect digits, least significant first
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      dividend  <= DIV_W'(magnitude);
      rem       <= '0;
      negative  <= raw[VALUE_BITS-1];
      digit_cnt <= '0;
    end else if (cmd.div_step) begin
      dividend <= dividend_next;
      rem      <= rem_next;
    end else if (cmd.push_digit) begin
      digits[digit_cnt[IDX_W-1:0]] <= rem;
      rd_ptr    <= digit_cnt[IDX_W-1:0];
      digit_cnt <= digit_cnt + 1'b1;
      rem       <= '0;
    end else if (cmd.emit_digit) begin
      rd_ptr <= rd_ptr - 1'b1;
    end
  end

  // Drive one symbol per strobe, most significant digit first
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= cmd.emit_sign | cmd.emit_digit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_sign) begin
      symbol <= MINUS_SYMBOL;
      last   <= 1'b0;
    end else if (cmd.emit_digit) begin
      symbol <= alphabet[{digits[rd_ptr], 3'b000} +: SYM_W];
      last   <= (rd_ptr == '0);
    end
  end

  assign status.negative    = negative;
  assign status.quot_zero   = (dividend == '0);
  assign status.first_digit = (rd_ptr == '0);

endmodule

`default_nettype wire

@@ sv/integer_to_radix_digits_unit.sv @@
// Channel   Handshake            Payload                   Accepted when
// -------   ------------------   -----------------------   -------------------------
// input     start / busy         value[31:0] signed        start && !busy
// config    cfg_valid/cfg_ready  cfg_index[1:0], cfg_data  cfg_valid && cfg_ready
// result    strobe               symbol[7:0], last         strobe (one cycle each)
//
// After an item is taken, busy stays high while each digit passes through the
// four-bit-per-cycle radix divider and is then stored, and while its symbols
// are emitted, one per cycle, the minus sign first for a negative value.
// Worst case is the most negative value in radix 2: 32 digits and a sign.
// Reset restores radix 10 and the "0123456789ABCDEF" alphabet and idles the
// controller. Results cannot be stalled; cfg_ready is always high.
`timescale 1ns / 1ps
`default_nettype none

module integer_to_radix_digits_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic signed [i2r_pkg::IN_W-1:0]   value,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [i2r_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [i2r_pkg::CFG_W-1:0]         cfg_data,
  output logic                              strobe,
  output logic [i2r_pkg::SYM_W-1:0]         symbol,
  output logic                              last
);
  import i2r_pkg::*;

  logic [RADIX_W-1:0] radix;
  logic [CFG_W-1:0]   symbols_low;
  logic [CFG_W-1:0]   symbols_high;
  i2r_cmd_t           cmd;
  i2r_status_t        status;

  assign cfg_ready = 1'b1;

  // Hold configuration registers; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      radix        <= RADIX_RESET;
      symbols_low  <= SYMBOLS_LOW_RESET;
      symbols_high <= SYMBOLS_HIGH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_RADIX:        radix        <= cfg_data[RADIX_W-1:0];
        CFG_SYMBOLS_LOW:  symbols_low  <= cfg_data;
        CFG_SYMBOLS_HIGH: symbols_high <= cfg_data;
        default: ;
      endcase
    end
  end

  i2r_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  i2r_datapath u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .value    (value),
    .radix    (radix),
    .alphabet ({symbols_high, symbols_low}),
    .status   (status),
    .symbol   (symbol),
    .last     (last),
    .strobe   (strobe)
  );

`ifndef SYNTH
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("item taken but unit not busy");
  a_strobe_from_busy: assert property (@(posedge clk) disable iff (rst)
    strobe |-> $past(busy))
    else $error("symbol emitted while idle");
  a_more_follows: assert property (@(posedge clk) disable iff (rst)
    (strobe && !last) |-> busy)
    else $error("run ended without last symbol");
  a_gap_after_last: assert property (@(posedge clk) disable iff (rst)
    (strobe && last) |=> !strobe)
    else $error("symbol right after last");
`endif

endmodule

`default_nettype wire
